// ===== design/dhl_pkg.sv =====
package dhl_pkg;

    localparam int DHL_STAGES      = 7;
    localparam int DHL_SINE_STAGES = 4;

    localparam logic [16:0] DHL_QUARTER = 17'h08000;
    localparam logic [15:0] DHL_X_FULL  = 16'h8000;
    localparam logic [30:0] DHL_POLY_A  = 31'd1686629713;
    localparam logic [29:0] DHL_POLY_B  = 30'd688904866;
    localparam logic [26:0] DHL_POLY_C  = 27'd76016977;

    localparam int DHL_SA = 0;
    localparam int DHL_CA = 1;
    localparam int DHL_ST = 2;
    localparam int DHL_CT = 3;
    localparam int DHL_SJ = 4;
    localparam int DHL_CJ = 5;
    localparam int DHL_TRIGS = 6;

    typedef struct packed {
        logic signed [15:0] twist_angle;
        logic signed [15:0] joint_angle;
        logic signed [31:0] link_length;
        logic signed [31:0] link_offset;
    } t_dhl_in;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_dhl_out;

    typedef struct packed {
        logic [DHL_SINE_STAGES-1:0] sine;
        logic                       prod;
        logic                       round;
    } t_dhl_en;

endpackage

// ===== design/dh_link_to_pose_core.sv =====
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    i_in_data  (t_dhl_in)
// out      output     o_out_valid / i_out_ready  o_out_data (t_dhl_out)
//
// One transaction per cycle sustained while i_out_ready is high.
// Depth is set by the input register, the six sine pipelines (four stages each) and the product and rounding stages.
// Synchronous active-low reset clears only the stage valid bits.
// Stages advance independently, so bubbles close up under an output stall;
// o_in_ready drops only when all seven stages hold a transaction.
module dh_link_to_pose_core
    import dhl_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dhl_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dhl_out o_out_data
);

    logic [DHL_STAGES-1:0] r_vld, n_vld;
    logic [DHL_STAGES:0]   en;
    t_dhl_en               stage_en;

    t_dhl_in r_in;

    logic [DHL_TRIGS-1:0][16:0] phase;
    logic [DHL_TRIGS-1:0][30:0] mag;
    logic [DHL_TRIGS-1:0]       neg;

    logic [31:0]        n_lmag;
    logic [31:0]        r_lmag [DHL_SINE_STAGES];
    logic               r_lneg [DHL_SINE_STAGES];
    logic signed [31:0] r_off  [DHL_SINE_STAGES];

    always_comb begin
        en[DHL_STAGES] = i_out_ready;
        for (int k = DHL_STAGES - 1; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
        n_vld[0] = en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < DHL_STAGES; k++) begin
            n_vld[k] = en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign stage_en.sine  = en[DHL_SINE_STAGES:1];
    assign stage_en.prod  = en[DHL_SINE_STAGES+1];
    assign stage_en.round = en[DHL_SINE_STAGES+2];

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_in <= i_in_data;
        end
    end

    always_comb begin
        phase[DHL_SA] = {r_in.twist_angle[15], r_in.twist_angle};
        phase[DHL_CA] = {r_in.twist_angle[15], r_in.twist_angle} + DHL_QUARTER;
        phase[DHL_ST] = {r_in.joint_angle[15], r_in.joint_angle};
        phase[DHL_CT] = {r_in.joint_angle[15], r_in.joint_angle} + DHL_QUARTER;
        phase[DHL_SJ] = {r_in.joint_angle, 1'b0};
        phase[DHL_CJ] = {r_in.joint_angle, 1'b0} + DHL_QUARTER;
        n_lmag = r_in.link_length[31] ? (32'd0 - r_in.link_length) : r_in.link_length;
    end

    for (genvar g = 0; g < DHL_TRIGS; g++) begin : g_sine
        dhl_sine u_sine (
            .i_clk   (i_clk),
            .i_en    (stage_en.sine),
            .i_phase (phase[g]),
            .o_mag   (mag[g]),
            .o_neg   (neg[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_lmag[0] <= n_lmag;
            r_lneg[0] <= r_in.link_length[31];
            r_off[0]  <= r_in.link_offset;
        end
        for (int k = 1; k < DHL_SINE_STAGES; k++) begin
            if (en[k+1]) begin
                r_lmag[k] <= r_lmag[k-1];
                r_lneg[k] <= r_lneg[k-1];
                r_off[k]  <= r_off[k-1];
            end
        end
    end

    dhl_combine u_combine (
        .i_clk    (i_clk),
        .i_en     (stage_en),
        .i_mag    (mag),
        .i_neg    (neg),
        .i_lmag   (r_lmag[DHL_SINE_STAGES-1]),
        .i_lneg   (r_lneg[DHL_SINE_STAGES-1]),
        .i_offset (r_off[DHL_SINE_STAGES-1]),
        .o_data   (o_out_data)
    );

    assign o_in_ready  = en[0];
    assign o_out_valid = r_vld[DHL_STAGES-1];

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (&r_vld && !i_out_ready))
        else $error("input stalled while pipeline has room");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !(o_out_valid && i_out_ready))
        |=> ($countones(r_vld) == $past($countones(r_vld)) + 1))
        else $error("transaction lost or duplicated in pipeline");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(i_in_valid && o_in_ready) && o_out_valid && i_out_ready)
        |=> ($countones(r_vld) + 1 == $past($countones(r_vld))))
        else $error("delivered transaction not retired");

    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.quat_w <= 16'sd16384 && o_out_data.quat_w >= -16'sd16384
                      && o_out_data.quat_z <= 16'sd16384 && o_out_data.quat_z >= -16'sd16384))
        else $error("quaternion part out of range");

endmodule

// ===== design/dhl_sine.sv =====
module dhl_sine
    import dhl_pkg::*;
(
    input  logic                       i_clk,
    input  logic [DHL_SINE_STAGES-1:0] i_en,
    input  logic [16:0]                i_phase,
    output logic [30:0]                o_mag,
    output logic                       o_neg
);

    logic [15:0] n1_x;
    logic [31:0] p1;
    logic [57:0] p2;
    logic [60:0] p3;
    logic [46:0] p4;
    logic [29:0] n2_t1;
    logic [30:0] n3_t2;

    logic [15:0] r1_x, r2_x, r3_x;
    logic [30:0] r1_x2, r2_x2;
    logic        r1_neg, r2_neg, r3_neg, r4_neg;
    logic [29:0] r2_t1;
    logic [30:0] r3_t2;
    logic [30:0] r4_s;

    always_comb begin
        if (i_phase[15]) begin
            n1_x = DHL_X_FULL - {1'b0, i_phase[14:0]};
        end else begin
            n1_x = {1'b0, i_phase[14:0]};
        end
        p1    = 32'(n1_x) * 32'(n1_x);
        p2    = 58'(DHL_POLY_C) * 58'(r1_x2);
        n2_t1 = DHL_POLY_B - {2'b00, p2[57:30]};
        p3    = 61'(r2_x2) * 61'(r2_t1);
        n3_t2 = DHL_POLY_A - p3[60:30];
        p4    = 47'(r3_t2) * 47'(r3_x);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_x   <= n1_x;
            r1_x2  <= p1[30:0];
            r1_neg <= i_phase[16];
        end
        if (i_en[1]) begin
            r2_x   <= r1_x;
            r2_x2  <= r1_x2;
            r2_t1  <= n2_t1;
            r2_neg <= r1_neg;
        end
        if (i_en[2]) begin
            r3_x   <= r2_x;
            r3_t2  <= n3_t2;
            r3_neg <= r2_neg;
        end
        if (i_en[3]) begin
            r4_s   <= p4[45:15];
            r4_neg <= r3_neg;
        end
    end

    assign o_mag = r4_s;
    assign o_neg = r4_neg;

endmodule

// ===== design/dhl_combine.sv =====
module dhl_combine
    import dhl_pkg::*;
(
    input  logic                        i_clk,
    input  t_dhl_en                     i_en,
    input  logic [DHL_TRIGS-1:0][30:0]  i_mag,
    input  logic [DHL_TRIGS-1:0]        i_neg,
    input  logic [31:0]                 i_lmag,
    input  logic                        i_lneg,
    input  logic signed [31:0]          i_offset,
    output t_dhl_out                    o_data
);

    logic [3:0][61:0] qp;
    logic [1:0][62:0] pp;
    logic [3:0]       n_qneg;
    logic [1:0]       n_pdiff;

    logic [3:0][60:0] r_qprod;
    logic [3:0]       r_qneg;
    logic [1:0][61:0] r_pprod;
    logic [1:0]       r_pdiff;
    logic signed [31:0] r_off;

    logic [3:0][61:0] qsum;
    logic [3:0][15:0] qres;
    logic [1:0][62:0] psum;
    logic [1:0][31:0] pres;
    t_dhl_out         n_out;
    t_dhl_out         r_out;

    always_comb begin
        qp[0] = 62'(i_mag[DHL_CT]) * 62'(i_mag[DHL_CA]);
        qp[1] = 62'(i_mag[DHL_CT]) * 62'(i_mag[DHL_SA]);
        qp[2] = 62'(i_mag[DHL_ST]) * 62'(i_mag[DHL_SA]);
        qp[3] = 62'(i_mag[DHL_ST]) * 62'(i_mag[DHL_CA]);
        n_qneg[0] = i_neg[DHL_CT] ^ i_neg[DHL_CA];
        n_qneg[1] = i_neg[DHL_CT] ^ i_neg[DHL_SA];
        n_qneg[2] = i_neg[DHL_ST] ^ i_neg[DHL_SA];
        n_qneg[3] = i_neg[DHL_ST] ^ i_neg[DHL_CA];
        pp[0] = 63'(i_lmag) * 63'(i_mag[DHL_CJ]);
        pp[1] = 63'(i_lmag) * 63'(i_mag[DHL_SJ]);
        n_pdiff[0] = i_lneg ^ i_neg[DHL_CJ];
        n_pdiff[1] = i_lneg ^ i_neg[DHL_SJ];
    end

    always_ff @(posedge i_clk) begin
        if (i_en.prod) begin
            for (int k = 0; k < 4; k++) begin
                r_qprod[k] <= qp[k][60:0];
            end
            for (int k = 0; k < 2; k++) begin
                r_pprod[k] <= pp[k][61:0];
            end
            r_qneg  <= n_qneg;
            r_pdiff <= n_pdiff;
            r_off   <= i_offset;
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            qsum[k] = {1'b0, r_qprod[k]} + (62'd1 << 45);
            qres[k] = r_qneg[k] ? (16'd0 - qsum[k][61:46]) : qsum[k][61:46];
        end
        for (int k = 0; k < 2; k++) begin
            psum[k] = {1'b0, r_pprod[k]} + (63'd1 << 29);
            if (r_pdiff[k]) begin
                pres[k] = 32'd0 - psum[k][61:30];
            end else if (psum[k][61]) begin
                pres[k] = 32'h7FFF_FFFF;
            end else begin
                pres[k] = psum[k][61:30];
            end
        end
        n_out.quat_w = $signed(qres[0]);
        n_out.quat_x = $signed(qres[1]);
        n_out.quat_y = $signed(qres[2]);
        n_out.quat_z = $signed(qres[3]);
        n_out.pos_x  = $signed(pres[0]);
        n_out.pos_y  = $signed(pres[1]);
        n_out.pos_z  = r_off;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.round) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule
